// ===== design/signed_int_to_decimal_ascii_defines.svh =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_defines
// assertion macros shared by the decimal text converter
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SIDTA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SIDTA_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/sidta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_pkg
// constants and types for the signed integer to decimal text converter
// ----------------------------------------------------------------------------
package sidta_pkg;

	// width of the binary magnitude and number of decimal digit cells
	localparam int MagWidth  = 32;
	localparam int NumDigits = 10;
	localparam int CntWidth  = $clog2(MagWidth);
	localparam int PosWidth  = $clog2(NumDigits + 1);

	localparam logic [CntWidth-1:0] CntLast = CntWidth'(MagWidth - 1);
	localparam logic [PosWidth-1:0] LastPos = PosWidth'(NumDigits - 1);

	// ascii codes
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharMinus = 8'h2D;

	typedef logic [3:0] digit_t;

	// per-cycle command to every digit cell
	typedef struct packed {
		logic clear;
		logic dabble;
		logic move;
	} cell_ctl_t;

endpackage

// ===== design/sidta_bcd_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sidta_bcd_cell
// one decimal digit of the shift-and-add-3 chain; also shifts digits upward
// ----------------------------------------------------------------------------
module sidta_bcd_cell import sidta_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      bit_in,
	input  digit_t    digit_in,
	output digit_t    digit,
	output logic      carry_out
);

	digit_t digit_q;
	digit_t adj;

	// add 3 when the digit would overflow on doubling
	always_comb begin
		adj = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
	end

	assign carry_out = adj[3];
	assign digit     = digit_q;

	// clear, double-and-insert, or take the lower neighbor's digit
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			digit_q <= '0;
		end else if (ctl.dabble) begin
			digit_q <= {adj[2:0], bit_in};
		end else if (ctl.move) begin
			digit_q <= digit_in;
		end
	end

endmodule

// ===== design/signed_int_to_decimal_ascii.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// signed 32-bit integer to decimal ascii text, one character per beat
// ----------------------------------------------------------------------------
// Input channel: value with in_valid / in_stall. One beat is one integer.
// Output channel: text_char / last_char with out_valid / out_stall. Each
// number gives its decimal text, most significant character first, with a
// leading '-' when negative and no leading zeros; zero gives "0". last_char
// marks the final character of each number.
// Timing: the magnitude is shifted through a row of ten digit cells, one bit
// a cycle. A negative number then gives the '-' character, leading zeros are
// dropped, and each kept digit goes into the output register in turn, most
// significant first. Only one number is in work at a time.
// Stall: the output register holds its beat while out_stall is high, and the
// controller waits before loading the next sign or kept digit; nothing is lost.
// Reset: arst_n clears the controller and empties the output register.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_defines.svh"

module signed_int_to_decimal_ascii import sidta_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic signed [31:0] value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  text_char,
	output logic        last_char
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [MagWidth-1:0]   mag_q;
	logic                  neg_q;
	logic [CntWidth-1:0]   bit_cnt_q;
	logic [PosWidth-1:0]   pos_q;
	logic                  started_q;
	logic                  out_valid_q;
	logic [7:0]            text_char_q;
	logic                  last_char_q;

	logic                  in_accept;
	logic                  can_load;
	logic                  out_load;
	logic                  skip;
	logic [MagWidth-1:0]   abs_val;
	cell_ctl_t             cell_ctl;
	logic   [NumDigits:0]  dab_link;
	digit_t [NumDigits:0]  dig_link;
	digit_t                top_digit;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign can_load  = !out_valid_q || !out_stall;

	// magnitude as unsigned, most negative value wraps to itself
	assign abs_val = value[31] ? (MagWidth'(0) - unsigned'(value)) : unsigned'(value);

	// chain of digit cells, cell 0 is the least significant digit
	assign dab_link[0] = mag_q[MagWidth-1];
	assign dig_link[0] = '0;
	assign top_digit   = dig_link[NumDigits];

	// leading zero suppression, keeping at least the units digit
	assign skip = !started_q && (top_digit == 4'd0) && (pos_q != LastPos);

	// output register takes a beat for the sign or a kept digit
	assign out_load = can_load && ((state_q == ST_SIGN) || ((state_q == ST_EMIT) && !skip));

	always_comb begin
		cell_ctl.clear  = in_accept;
		cell_ctl.dabble = (state_q == ST_CONV);
		cell_ctl.move   = (state_q == ST_EMIT) && (skip || can_load);
	end

	for (genvar i = 0; i < NumDigits; i++) begin : g_cell
		sidta_bcd_cell u_cell (
			.clk      (clk),
			.ctl      (cell_ctl),
			.bit_in   (dab_link[i]),
			.digit_in (dig_link[i]),
			.digit    (dig_link[i+1]),
			.carry_out(dab_link[i+1])
		);
	end

	// controller and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			bit_cnt_q   <= '0;
			pos_q       <= '0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			text_char_q <= '0;
			last_char_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						mag_q     <= abs_val;
						neg_q     <= value[31];
						bit_cnt_q <= '0;
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					mag_q     <= {mag_q[MagWidth-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q + 1'b1;
					if (bit_cnt_q == CntLast) begin
						pos_q     <= '0;
						started_q <= 1'b0;
						state_q   <= neg_q ? ST_SIGN : ST_EMIT;
					end
				end
				ST_SIGN: begin
					if (can_load) begin
						text_char_q <= CharMinus;
						last_char_q <= 1'b0;
						state_q     <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (skip) begin
						pos_q <= pos_q + 1'b1;
					end else if (can_load) begin
						text_char_q <= CharZero + {4'b0000, top_digit};
						last_char_q <= (pos_q == LastPos);
						pos_q       <= pos_q + 1'b1;
						started_q   <= 1'b1;
						if (pos_q == LastPos) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign text_char = text_char_q;
	assign last_char = last_char_q;

	// checks
	`SIDTA_ASSERT_IMP(a_no_digit_overflow, state_q == ST_CONV, !dab_link[NumDigits], "overflow")
	`SIDTA_ASSERT_IMP(a_digit_is_decimal, state_q == ST_EMIT, top_digit <= 4'd9, "bad digit")
	`SIDTA_ASSERT_IMP(a_pos_in_range, state_q == ST_EMIT, pos_q <= LastPos, "position overrun")
	`SIDTA_ASSERT_NXT(a_accept_starts_conv, in_accept, state_q == ST_CONV && bit_cnt_q == '0, "no start")

endmodule

// ===== tb/signed_int_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// self-checking bench for the signed integer to decimal text converter
// ----------------------------------------------------------------------------
// Numbers go in on the input channel. For each number the bench builds the
// decimal text it expects: a minus sign for negatives, digits most
// significant first, no leading zeros, a last mark on the final character.
// Each output beat is checked against the oldest expected character. The
// stimulus starts with the corner values, then random numbers of every digit
// length and sign. The sender runs in bursts and the receiver stalls in
// changing patterns. It also holds off once for a long stretch, and the
// sender waits now and then until all text has drained.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
	import sidta_pkg::*;

	localparam int RandomItems = 450;
	localparam int HoldCycles  = 400;
	localparam int MaxReports  = 30;

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} text_beat_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_stall;
	logic signed [31:0] value     = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [7:0]         text_char;
	logic               last_char;

	// numbers still to send, and whether to drain all text before each one
	logic signed [31:0] numbers_to_send[$];
	bit                 drain_first[$];
	// characters still owed by the block, oldest first
	text_beat_t         owed_text[$];

	bit in_took = 1'b0;
	int n_numbers  = 0;
	int n_chars    = 0;
	int n_negative = 0;
	int n_longest  = 0;
	int n_errors   = 0;
	longint pow10[11];

	signed_int_to_decimal_ascii dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.text_char (text_char),
		.last_char (last_char)
	);

	// clock, 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// append the expected decimal text of one number
	function automatic void queue_decimal_text(input logic signed [31:0] num);
		logic [31:0] mag;
		digit_t      digs[10];
		int          nd;
		int          len;
		text_beat_t  b;
		nd = 0;
		// the magnitude stays unsigned, so the most negative value is fine
		mag = num[31] ? (32'd0 - $unsigned(num)) : $unsigned(num);
		do begin
			digs[nd] = digit_t'(mag % 32'd10);
			mag = mag / 32'd10;
			nd++;
		end while (mag != 0 && nd < 10);
		len = nd;
		if (num[31]) begin
			b.ch = CharMinus;
			b.last = 1'b0;
			owed_text.push_back(b);
			n_negative++;
			len++;
		end
		for (int k = nd - 1; k >= 0; k--) begin
			b.ch = CharZero + 8'(digs[k]);
			b.last = (k == 0);
			owed_text.push_back(b);
		end
		if (len == 11) n_longest++;
	endfunction

	// random number: full range, a chosen digit length, small, or near a boundary
	function automatic logic signed [31:0] pick_number();
		logic signed [31:0] v;
		int nd;
		longint lo;
		longint hi;
		nd = $urandom_range(1, 10);
		case ($urandom_range(0, 5))
			0, 1: begin
				v = $urandom;
			end
			2, 3: begin
				lo = (nd == 1) ? 0 : pow10[nd - 1];
				hi = (nd == 10) ? 64'd2147483647 : pow10[nd] - 1;
				v = 32'(lo + longint'($urandom_range(0, 32'(hi - lo))));
				if ($urandom_range(0, 1)) v = -v;
			end
			4: begin
				v = $urandom_range(0, 19);
				if ($urandom_range(0, 1)) v = -v;
			end
			default: begin
				if (nd == 10) begin
					v = $urandom_range(0, 1) ? 32'h7FFF_FFFF - $urandom_range(0, 3)
						: 32'h8000_0000 + $urandom_range(0, 3);
				end else begin
					v = 32'(pow10[nd] - 2 + $urandom_range(0, 3));
					if ($urandom_range(0, 1)) v = -v;
				end
			end
		endcase
		return v;
	endfunction

	// sample both channels at the rising edge
	always @(posedge clk) begin
		in_took <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				queue_decimal_text(value);
				n_numbers++;
			end
			if (out_valid === 1'b1 && out_stall == 1'b0) begin
				if (owed_text.size() == 0) begin
					n_errors++;
					if (n_errors <= MaxReports)
						$display("%0t: unexpected character 0x%02h last=%b",
							$time, text_char, last_char);
				end else begin
					text_beat_t b;
					b = owed_text.pop_front();
					n_chars++;
					if (text_char !== b.ch) begin
						n_errors++;
						if (n_errors <= MaxReports)
							$display("%0t: text_char expected 0x%02h actual 0x%02h",
								$time, b.ch, text_char);
					end
					if (last_char !== b.last) begin
						n_errors++;
						if (n_errors <= MaxReports)
							$display("%0t: last_char expected %b actual %b",
								$time, b.last, last_char);
					end
				end
			end
		end
	end

	// sender: bursts of beats with random gaps, optional drain before a number
	int burst_left = 1;
	int gap_left   = 0;
	always @(negedge clk) begin
		bit next_valid;
		next_valid = in_valid;
		if (!arst_n) begin
			next_valid = 1'b0;
		end else begin
			if (in_valid && in_took) begin
				void'(numbers_to_send.pop_front());
				void'(drain_first.pop_front());
				next_valid = 1'b0;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
			if (!next_valid && numbers_to_send.size() > 0) begin
				if (gap_left > 0)
					gap_left--;
				else if (!(drain_first[0] && owed_text.size() != 0))
					next_valid = 1'b1;
			end
		end
		in_valid <= next_valid;
		value <= next_valid ? numbers_to_send[0] : 32'($urandom);
	end

	// receiver: stall pattern changes now and then, plus one long hold-off
	rx_mode_t rx_mode    = RX_FREE;
	int       mode_left  = 0;
	int       hold_left  = 0;
	bit       hold_done  = 1'b0;
	int       rx_cycle   = 0;
	always @(negedge clk) begin
		bit next_stall;
		next_stall = 1'b0;
		rx_cycle++;
		if (hold_left > 0) begin
			hold_left--;
			next_stall = 1'b1;
		end else if (!hold_done && n_numbers >= 60) begin
			hold_done = 1'b1;
			hold_left = HoldCycles;
			next_stall = 1'b1;
		end else begin
			if (mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 200);
			end else begin
				mode_left--;
			end
			case (rx_mode)
				RX_FREE:     next_stall = 1'b0;
				RX_LIGHT:    next_stall = ($urandom_range(0, 3) == 0);
				RX_HEAVY:    next_stall = ($urandom_range(0, 3) != 0);
				RX_PERIODIC: next_stall = ((rx_cycle % 7) < 3);
				default:     next_stall = 1'b0;
			endcase
		end
		out_stall <= next_stall;
	end

	// stimulus, reset and end of run
	initial begin
		logic signed [31:0] corners[$];
		pow10[0] = 1;
		for (int i = 1; i < 11; i++) pow10[i] = pow10[i - 1] * 10;

		// corner values: zero, one digit, powers of ten, extremes
		corners = '{32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10,
			32'sd99, 32'sd100, -32'sd100, 32'sd999999999, -32'sd999999999,
			32'sd1000000000, -32'sd1000000000, 32'sd1234567890, -32'sd1234567890,
			32'sd2147483647, -32'sd2147483647, 32'sh8000_0000, 32'sd2000000000,
			32'sd1000000001, 32'sd505};
		foreach (corners[i]) begin
			numbers_to_send.push_back(corners[i]);
			drain_first.push_back(1'b0);
		end
		for (int i = 0; i < RandomItems; i++) begin
			numbers_to_send.push_back(pick_number());
			drain_first.push_back(i == 0 || i == 150 || i == 300);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (numbers_to_send.size() != 0 || owed_text.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("covered %0d numbers, %0d characters checked", n_numbers, n_chars);
		$display("%0d negative, %0d of full eleven-character length",
			n_negative, n_longest);
		if (n_errors == 0 && owed_text.size() == 0) begin
			$display("signed_int_to_decimal_ascii_tb: PASS");
		end else begin
			$display("signed_int_to_decimal_ascii_tb: FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#10_000_000;
		$display("signed_int_to_decimal_ascii_tb: FAIL");
		$finish;
	end

endmodule
